[rtl/bdi_pkg.sv]
// bdi_pkg: shared types, codes and constants of the ballistic drag integrator
// used by the interfaces, the iterative root/divide unit and the top level
// no dependencies
package bdi_pkg;

    // field widths
    localparam int POS_W   = 32;
    localparam int VEL_W   = 32;
    localparam int AIM_W   = 16;
    localparam int DT_W    = 18;
    localparam int MUZ_W   = 18;
    localparam int DRAG_W  = 16;
    localparam int LIFE_W  = 26;
    localparam int GRAV_W  = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 26;

    // iterative unit
    localparam int IU_W      = 64;
    localparam int IU_STEP_W = 7;
    localparam int ROOT_STEPS = 32;
    localparam int QUO_W     = 51;

    // defaults and fixed numbers
    localparam int SUBSTEPS_DEF = 4;
    localparam logic [MUZ_W-1:0]  MUZZLE_RST   = 18'd80000;
    localparam logic [DRAG_W-1:0] DRAG_RST     = 16'd16;
    localparam logic [LIFE_W-1:0] MAX_LIFE_RST = 26'd5242880;
    localparam logic [GRAV_W-1:0] GRAV_RST     = 13'h1C2C;  // -980
    localparam logic [63:0]       AIM_MIN_SQ   = 64'd10;

    typedef enum logic {
        OP_LAUNCH = 1'b0,
        OP_TICK   = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MUZZLE_SPEED   = 2'd0,
        CFG_DRAG_OVER_MASS = 2'd1,
        CFG_MAX_LIFE       = 2'd2,
        CFG_GRAVITY_Z      = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_L_SQ,
        ST_L_SQA,
        ST_L_CHK,
        ST_L_ROOT,
        ST_L_MUL,
        ST_L_MULA,
        ST_L_DIV,
        ST_T_DIV,
        ST_T_GMUL,
        ST_T_GMULA,
        ST_S_SQ,
        ST_S_SQA,
        ST_S_ROOT,
        ST_S_KS,
        ST_S_KSA,
        ST_S_F1A,
        ST_S_F2A,
        ST_S_V,
        ST_S_VA,
        ST_S_P,
        ST_S_PA,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic                 sqrt_mode;
        logic [IU_STEP_W-1:0] steps;
        logic [31:0]          divisor;
        logic [IU_W-1:0]      operand;
    } t_iu_cmd;

    typedef struct packed {
        logic            done;
        logic [IU_W-1:0] result;
    } t_iu_rsp;

endpackage

[rtl/bdi_if.sv]
// bdi_if: request, result and register write channels of the integrator
// depends on bdi_pkg for field widths
interface bdi_in_if
    import bdi_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic signed [POS_W-1:0]  launch_x;
    logic signed [POS_W-1:0]  launch_y;
    logic signed [POS_W-1:0]  launch_z;
    logic signed [AIM_W-1:0]  aim_x;
    logic signed [AIM_W-1:0]  aim_y;
    logic signed [AIM_W-1:0]  aim_z;
    logic [DT_W-1:0]          delta_time;

    modport source (output valid, opcode, launch_x, launch_y, launch_z,
                    aim_x, aim_y, aim_z, delta_time, input ready);
    modport sink   (input valid, opcode, launch_x, launch_y, launch_z,
                    aim_x, aim_y, aim_z, delta_time, output ready);
endinterface

interface bdi_out_if
    import bdi_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  seg_start_x;
    logic signed [POS_W-1:0]  seg_start_y;
    logic signed [POS_W-1:0]  seg_start_z;
    logic signed [POS_W-1:0]  seg_end_x;
    logic signed [POS_W-1:0]  seg_end_y;
    logic signed [POS_W-1:0]  seg_end_z;
    logic                     expired;
    logic                     last;

    modport source (output valid, seg_start_x, seg_start_y, seg_start_z,
                    seg_end_x, seg_end_y, seg_end_z, expired, last, input ready);
    modport sink   (input valid, seg_start_x, seg_start_y, seg_start_z,
                    seg_end_x, seg_end_y, seg_end_z, expired, last, output ready);
endinterface

interface bdi_cfg_if
    import bdi_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/ballistic_drag_integrator_core.sv]
// ballistic_drag_integrator_core: projectile integrator with quadratic drag
// depends on bdi_pkg, bdi_if, bdi_mul and bdi_root_div
//
//  port     dir   kind          carries
//  i_req    in    valid/ready   launch or tick request
//  o_rsp    out   valid/ready   segment or expiry result
//  i_cfg    in    valid/ready   register write, index and data
//
// one request at a time; i_req.ready is high only while idle
// launch: a 32-step root and three 51-step divides in the shared root/divide
//   unit, none of them for a near-zero aim, which launches at rest
// tick: SUBSTEPS substeps, each ending in a result that may stall; each substep
//   runs a 32-step root and the shared multiplier; expiry follows in the next cycle
// reset is synchronous; registers return to their defaults, projectile dead
// a stalled result holds the sequencer in place until o_rsp.ready
module ballistic_drag_integrator_core
    import bdi_pkg::*;
#(
    parameter int SUBSTEPS = SUBSTEPS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    bdi_in_if.sink    i_req,
    bdi_out_if.source o_rsp,
    bdi_cfg_if.sink   i_cfg
);
    localparam int SUB_W = (SUBSTEPS > 1) ? $clog2(SUBSTEPS) : 1;

    // substep length by reciprocal multiply: floor(dt * DT_RECIP / 2^DT_RSH)
    localparam int          DT_RSH   = 30;
    localparam logic [31:0] DT_RECIP = 32'((64'd1 << DT_RSH) / SUBSTEPS + 64'd1);

    // magnitude helpers
    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [15:0] mag16(input logic [15:0] v);
        mag16 = v[15] ? (~v + 16'd1) : v;
    endfunction

    function automatic logic [12:0] mag13(input logic [12:0] v);
        mag13 = v[12] ? (~v + 13'd1) : v;
    endfunction

    // clamp a 35-bit two's complement value to 32 bits
    function automatic logic [31:0] sat35(input logic [34:0] v);
        if ((v[34:31] == 4'b0000) || (v[34:31] == 4'b1111)) begin
            sat35 = v[31:0];
        end else begin
            sat35 = v[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    endfunction

    // state
    t_state             r_state, n_state;
    logic [31:0]        r_pos   [3];
    logic [31:0]        n_pos   [3];
    logic [31:0]        r_vel   [3];
    logic [31:0]        n_vel   [3];
    logic [31:0]        r_start [3];
    logic [31:0]        n_start [3];
    logic [AIM_W-1:0]   r_aim   [3];
    logic [AIM_W-1:0]   n_aim   [3];
    logic [31:0]        r_life, n_life;
    logic               r_alive, n_alive;
    logic [1:0]         r_idx, n_idx;
    logic [SUB_W-1:0]   r_sub, n_sub;
    logic [63:0]        r_acc, n_acc;
    logic [31:0]        r_root, n_root;
    logic [23:0]        r_ks, n_ks;
    logic [46:0]        r_f, n_f;
    logic [DT_W-1:0]    r_dt, n_dt;
    logic [18:0]        r_gdv, n_gdv;
    logic               r_exp, n_exp;
    logic               r_last, n_last;

    // configuration registers
    logic [MUZ_W-1:0]   r_muzzle;
    logic [DRAG_W-1:0]  r_drag;
    logic [LIFE_W-1:0]  r_max_life;
    logic [GRAV_W-1:0]  r_grav;

    // shared units
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    t_iu_cmd     iu_cmd;
    t_iu_rsp     iu_rsp;

    bdi_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    bdi_root_div u_root_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (iu_cmd),
        .o_rsp   (iu_rsp)
    );

    // scratch
    logic [32:0]      life_sum;
    logic [32:0]      life_new;
    logic [QUO_W-1:0] num;
    logic [QUO_W-1:0] quo;
    logic [30:0]      grnd;
    logic [18:0]      gmag;
    logic [63:0]      sq_sum;
    logic [47:0]      fsum;
    logic [64:0]      drnd;
    logic [32:0]      dmag;
    logic [34:0]      vsum;
    logic [34:0]      dv;
    logic [50:0]      prnd;
    logic [34:0]      psum;
    logic [34:0]      pstep;

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_vel   = r_vel;
        n_start = r_start;
        n_aim   = r_aim;
        n_life  = r_life;
        n_alive = r_alive;
        n_idx   = r_idx;
        n_sub   = r_sub;
        n_acc   = r_acc;
        n_root  = r_root;
        n_ks    = r_ks;
        n_f     = r_f;
        n_dt    = r_dt;
        n_gdv   = r_gdv;
        n_exp   = r_exp;
        n_last  = r_last;
        mul_a   = '0;
        mul_b   = '0;
        iu_cmd  = '0;
        life_sum = {1'b0, r_life} + 33'(i_req.delta_time);
        life_new = life_sum[32] ? 33'h0_FFFF_FFFF : life_sum;
        num      = '0;
        quo      = iu_rsp.result[QUO_W-1:0];
        grnd     = {1'b0, mul_p[29:0]} + 31'd2048;
        gmag     = grnd[30:12];
        sq_sum   = r_acc + mul_p;
        fsum     = {1'b0, r_f} + 48'(mul_p[41:20]);
        drnd     = {1'b0, mul_p} + 65'h0_8000_0000;
        dmag     = r_f[32] ? {1'b0, mag32(r_vel[r_idx])} : drnd[64:32];
        dv       = r_vel[r_idx][31] ? {2'b00, dmag} : (35'd0 - {2'b00, dmag});
        vsum     = {{3{r_vel[r_idx][31]}}, r_vel[r_idx]} + dv
                 + ((r_idx == 2'd2) ? {{16{r_gdv[18]}}, r_gdv} : 35'd0);
        prnd     = {1'b0, mul_p[49:0]} + 51'h80_0000;
        pstep    = 35'(prnd[50:24]);
        psum     = r_vel[r_idx][31]
                 ? ({{3{r_pos[r_idx][31]}}, r_pos[r_idx]} - pstep)
                 : ({{3{r_pos[r_idx][31]}}, r_pos[r_idx]} + pstep);

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.opcode == OP_LAUNCH) begin
                        n_pos[0] = i_req.launch_x;
                        n_pos[1] = i_req.launch_y;
                        n_pos[2] = i_req.launch_z;
                        n_aim[0] = i_req.aim_x;
                        n_aim[1] = i_req.aim_y;
                        n_aim[2] = i_req.aim_z;
                        n_life   = '0;
                        n_alive  = 1'b1;
                        n_idx    = '0;
                        n_acc    = '0;
                        n_state  = ST_L_SQ;
                    end else if (!r_alive) begin
                        // dead projectile: report, state untouched
                        n_start = r_pos;
                        n_exp   = 1'b1;
                        n_last  = 1'b1;
                        n_state = ST_OUT;
                    end else begin
                        n_life = life_new[31:0];
                        if (life_new > 33'(r_max_life)) begin
                            n_alive = 1'b0;
                            n_start = r_pos;
                            n_exp   = 1'b1;
                            n_last  = 1'b1;
                            n_state = ST_OUT;
                        end else begin
                            // substep length by reciprocal multiply
                            mul_a   = 32'(i_req.delta_time);
                            mul_b   = DT_RECIP;
                            n_state = ST_T_DIV;
                        end
                    end
                end
            end

            // launch: squared aim length
            ST_L_SQ: begin
                mul_a   = 32'(mag16(r_aim[r_idx]));
                mul_b   = 32'(mag16(r_aim[r_idx]));
                n_state = ST_L_SQA;
            end
            ST_L_SQA: begin
                n_acc = sq_sum;
                if (r_idx == 2'd2) begin
                    n_idx   = '0;
                    n_state = ST_L_CHK;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = ST_L_SQ;
                end
            end
            ST_L_CHK: begin
                if (r_acc <= AIM_MIN_SQ) begin
                    // near-zero aim launches at rest
                    n_vel[0] = '0;
                    n_vel[1] = '0;
                    n_vel[2] = '0;
                    n_state  = ST_IDLE;
                end else begin
                    iu_cmd.start     = 1'b1;
                    iu_cmd.sqrt_mode = 1'b1;
                    iu_cmd.steps     = IU_STEP_W'(ROOT_STEPS);
                    iu_cmd.operand   = {r_acc[47:0], 16'h0000};
                    n_state          = ST_L_ROOT;
                end
            end
            ST_L_ROOT: begin
                if (iu_rsp.done) begin
                    n_root  = iu_rsp.result[31:0];
                    n_state = ST_L_MUL;
                end
            end
            ST_L_MUL: begin
                mul_a   = 32'(mag16(r_aim[r_idx]));
                mul_b   = 32'(r_muzzle);
                n_state = ST_L_MULA;
            end
            ST_L_MULA: begin
                // rounded quotient: add half the divisor first
                num              = {mul_p[34:0], 16'h0000} + QUO_W'(r_root[31:1]);
                iu_cmd.start     = 1'b1;
                iu_cmd.sqrt_mode = 1'b0;
                iu_cmd.steps     = IU_STEP_W'(QUO_W);
                iu_cmd.divisor   = r_root;
                iu_cmd.operand   = {num, {(IU_W-QUO_W){1'b0}}};
                n_state          = ST_L_DIV;
            end
            ST_L_DIV: begin
                if (iu_rsp.done) begin
                    if (r_aim[r_idx][AIM_W-1]) begin
                        n_vel[r_idx] = (quo > QUO_W'(32'h8000_0000))
                                     ? 32'h8000_0000 : (32'd0 - quo[31:0]);
                    end else begin
                        n_vel[r_idx] = (quo > QUO_W'(32'h7FFF_FFFF))
                                     ? 32'h7FFF_FFFF : quo[31:0];
                    end
                    if (r_idx == 2'd2) begin
                        n_idx   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 2'd1;
                        n_state = ST_L_MUL;
                    end
                end
            end

            // tick setup: substep length and gravity step
            ST_T_DIV: begin
                n_dt    = mul_p[DT_RSH +: DT_W];
                n_state = ST_T_GMUL;
            end
            ST_T_GMUL: begin
                mul_a   = 32'(mag13(r_grav));
                mul_b   = 32'(r_dt);
                n_state = ST_T_GMULA;
            end
            ST_T_GMULA: begin
                n_gdv   = r_grav[GRAV_W-1] ? (19'd0 - gmag) : gmag;
                n_sub   = '0;
                n_idx   = '0;
                n_acc   = '0;
                n_start = r_pos;
                n_state = ST_S_SQ;
            end

            // substep: speed from squared velocity
            ST_S_SQ: begin
                mul_a   = mag32(r_vel[r_idx]);
                mul_b   = mag32(r_vel[r_idx]);
                n_state = ST_S_SQA;
            end
            ST_S_SQA: begin
                n_acc = sq_sum;
                if (r_idx == 2'd2) begin
                    iu_cmd.start     = 1'b1;
                    iu_cmd.sqrt_mode = 1'b1;
                    iu_cmd.steps     = IU_STEP_W'(ROOT_STEPS);
                    iu_cmd.operand   = sq_sum;
                    n_idx            = '0;
                    n_state          = ST_S_ROOT;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = ST_S_SQ;
                end
            end
            ST_S_ROOT: begin
                if (iu_rsp.done) begin
                    n_root  = iu_rsp.result[31:0];
                    n_state = ST_S_KS;
                end
            end

            // drag fraction f = k*s*dt / 2^20 in two partial products
            ST_S_KS: begin
                mul_a   = 32'(r_drag);
                mul_b   = r_root;
                n_state = ST_S_KSA;
            end
            ST_S_KSA: begin
                n_ks    = mul_p[23:0];
                mul_a   = 32'(mul_p[47:24]);
                mul_b   = 32'(r_dt);
                n_state = ST_S_F1A;
            end
            ST_S_F1A: begin
                n_f     = {mul_p[42:0], 4'h0};
                mul_a   = 32'(r_ks);
                mul_b   = 32'(r_dt);
                n_state = ST_S_F2A;
            end
            ST_S_F2A: begin
                // drag can at most stop a component
                n_f     = (fsum > 48'h1_0000_0000) ? 47'h1_0000_0000 : fsum[46:0];
                n_idx   = '0;
                n_state = ST_S_V;
            end

            // velocity then position, one axis at a time
            ST_S_V: begin
                mul_a   = mag32(r_vel[r_idx]);
                mul_b   = r_f[31:0];
                n_state = ST_S_VA;
            end
            ST_S_VA: begin
                n_vel[r_idx] = sat35(vsum);
                n_state      = ST_S_P;
            end
            ST_S_P: begin
                mul_a   = mag32(r_vel[r_idx]);
                mul_b   = 32'(r_dt);
                n_state = ST_S_PA;
            end
            ST_S_PA: begin
                n_pos[r_idx] = sat35(psum);
                if (r_idx == 2'd2) begin
                    n_idx   = '0;
                    n_exp   = 1'b0;
                    n_last  = (r_sub == SUB_W'(SUBSTEPS - 1));
                    n_state = ST_OUT;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = ST_S_V;
                end
            end

            ST_OUT: begin
                if (o_rsp.ready) begin
                    if (r_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_sub   = r_sub + 1'b1;
                        n_start = r_pos;
                        n_acc   = '0;
                        n_idx   = '0;
                        n_state = ST_S_SQ;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '{default: '0};
            r_vel   <= '{default: '0};
            r_life  <= '0;
            r_alive <= 1'b0;
            r_idx   <= '0;
            r_sub   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_vel   <= n_vel;
            r_life  <= n_life;
            r_alive <= n_alive;
            r_idx   <= n_idx;
            r_sub   <= n_sub;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_aim   <= n_aim;
        r_acc   <= n_acc;
        r_root  <= n_root;
        r_ks    <= n_ks;
        r_f     <= n_f;
        r_dt    <= n_dt;
        r_gdv   <= n_gdv;
        r_exp   <= n_exp;
        r_last  <= n_last;
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_muzzle   <= MUZZLE_RST;
            r_drag     <= DRAG_RST;
            r_max_life <= MAX_LIFE_RST;
            r_grav     <= GRAV_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_MUZZLE_SPEED:   r_muzzle   <= i_cfg.data[MUZ_W-1:0];
                CFG_DRAG_OVER_MASS: r_drag     <= i_cfg.data[DRAG_W-1:0];
                CFG_MAX_LIFE:       r_max_life <= i_cfg.data[LIFE_W-1:0];
                CFG_GRAVITY_Z:      r_grav     <= i_cfg.data[GRAV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == ST_IDLE);

    // result register drive
    assign o_rsp.valid       = (r_state == ST_OUT);
    assign o_rsp.seg_start_x = r_start[0];
    assign o_rsp.seg_start_y = r_start[1];
    assign o_rsp.seg_start_z = r_start[2];
    assign o_rsp.seg_end_x   = r_pos[0];
    assign o_rsp.seg_end_y   = r_pos[1];
    assign o_rsp.seg_end_z   = r_pos[2];
    assign o_rsp.expired     = r_exp;
    assign o_rsp.last        = r_last;

    // no result offered while a new request could be taken
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_rsp.valid && i_req.ready))
        else $error("result valid while accepting requests");

    // the shared unit only finishes while the sequencer waits for it
    a_unit_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iu_rsp.done |-> (r_state == ST_L_ROOT || r_state == ST_L_DIV ||
                         r_state == ST_S_ROOT))
        else $error("unit finished outside a wait state");

    // an expiry result is always the only one of its request
    a_exp_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.expired) |-> o_rsp.last)
        else $error("expiry result not marked last");

    // after the final result the block is idle again
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.ready && o_rsp.last) |=> i_req.ready)
        else $error("not idle after final result");

endmodule

[rtl/bdi_mul.sv]
// bdi_mul: shared unsigned 32x32 multiplier with registered product
// depends on nothing but the clock
module bdi_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;
endmodule

[rtl/bdi_root_div.sv]
// bdi_root_div: iterative square root (two bits a step) and restoring divide
// (one bit a step) sharing one compare and subtract; depends on bdi_pkg
module bdi_root_div
    import bdi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_iu_cmd i_cmd,
    output t_iu_rsp o_rsp
);
    logic                 r_busy;
    logic                 r_done;
    logic                 r_mode;
    logic [IU_STEP_W-1:0] r_cnt;
    logic [IU_W-1:0]      r_x;
    logic [34:0]          r_rem;
    logic [IU_W-1:0]      r_q;
    logic [31:0]          r_div;

    logic [34:0] cand;
    logic [34:0] trial;
    logic [34:0] diff;
    logic        ge;

    always_comb begin
        if (r_mode) begin
            cand  = {r_rem[32:0], r_x[IU_W-1 -: 2]};
            trial = {r_q[32:0], 2'b01};
        end else begin
            cand  = {r_rem[33:0], r_x[IU_W-1]};
            trial = {3'b000, r_div};
        end
        ge   = (cand >= trial);
        diff = cand - trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.steps;
                r_mode <= i_cmd.sqrt_mode;
                r_div  <= i_cmd.divisor;
                r_x    <= i_cmd.operand;
                r_rem  <= '0;
                r_q    <= '0;
            end else if (r_busy) begin
                r_x   <= r_mode ? {r_x[IU_W-3:0], 2'b00} : {r_x[IU_W-2:0], 1'b0};
                r_rem <= ge ? diff : cand;
                r_q   <= {r_q[IU_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == IU_STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_q;
endmodule

[tb/tb_top.sv]
// tb_top: self-checking bench for ballistic_drag_integrator_core
// drives launch and tick requests and register writes, predicts every segment
// and expiry result in-bench; depends on bdi_pkg, bdi_if and the core rtl
module tb_top
    import bdi_pkg::*;
();

    localparam int IDLE_WAIT = 400;    // cycles for a launch still in flight
    localparam int WDOG_LIMIT = 6000;  // cycles with no handshake on any channel

    typedef struct packed {
        logic signed [31:0] sx, sy, sz, ex, ey, ez;
        logic               expired, last;
    } t_seg;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bdi_in_if  req_if ();
    bdi_out_if rsp_if ();
    bdi_cfg_if cfg_if ();

    ballistic_drag_integrator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    always #10 i_clk = ~i_clk;

    // model copy of registers and projectile state
    logic [MUZ_W-1:0]   muz_m;
    logic [DRAG_W-1:0]  drag_m;
    logic [LIFE_W-1:0]  max_life_m;
    logic [GRAV_W-1:0]  grav_m;
    logic signed [31:0] pos_m [3];
    logic signed [31:0] vel_m [3];
    logic [31:0]        life_m;
    logic               alive_m;

    t_seg seg_q [$];       // predicted results, oldest first
    int   n_err = 0;
    bit   no_idle = 1'b0;  // when set, neither side inserts gaps or stalls
    int   wdog = 0;
    int   rsp_stall = 0;

    // ---------------- arithmetic helpers ----------------
    function automatic longint unsigned root64(longint unsigned x);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint unsigned mag(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    // round to nearest, ties away from zero
    function automatic longint round_shift(longint num, int sh);
        longint unsigned q;
        q = (mag(num) + (64'd1 << (sh - 1))) >> sh;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [31:0] vel_next(logic signed [31:0] v,
                                                    longint unsigned f, longint g);
        longint unsigned d;
        longint dv;
        d  = (mag(longint'(v)) * f + (64'd1 << 31)) >> 32;
        dv = (v < 0) ? longint'(d) : -longint'(d);  // drag opposes motion
        return sat32(longint'(v) + dv + g);
    endfunction

    function automatic logic signed [31:0] aim_to_vel(longint a, longint unsigned len);
        longint unsigned q;
        q = (mag(a) * longint'(muz_m) * 65536 + len / 2) / len;
        return sat32((a < 0) ? -longint'(q) : longint'(q));
    endfunction

    // ---------------- predictor ----------------
    task automatic predict_launch(logic signed [31:0] lx, ly, lz,
                                  logic signed [15:0] ax, ay, az);
        longint ss;
        longint unsigned len;
        ss = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
        pos_m[0] = lx; pos_m[1] = ly; pos_m[2] = lz;
        if (ss <= 10) begin
            // near-zero aim gives a projectile at rest
            vel_m[0] = 0; vel_m[1] = 0; vel_m[2] = 0;
        end else begin
            len = root64(longint'(ss) << 16);
            vel_m[0] = aim_to_vel(ax, len);
            vel_m[1] = aim_to_vel(ay, len);
            vel_m[2] = aim_to_vel(az, len);
        end
        life_m  = 0;
        alive_m = 1'b1;
    endtask

    task automatic predict_tick(logic [DT_W-1:0] dtin);
        longint unsigned life_sum, dt, s, ks, f;
        longint gdv;
        t_seg r;
        if (alive_m) begin
            life_sum = longint'(life_m) + dtin;
            life_m = (life_sum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : life_sum[31:0];
            if (life_m > max_life_m) begin
                alive_m = 1'b0;
            end else begin
                dt  = dtin / SUBSTEPS_DEF;
                gdv = round_shift(longint'($signed(grav_m)) * longint'(dt), 12);
                for (int i = 0; i < SUBSTEPS_DEF; i++) begin
                    r.sx = pos_m[0]; r.sy = pos_m[1]; r.sz = pos_m[2];
                    s  = root64(mag(vel_m[0]) * mag(vel_m[0]) + mag(vel_m[1]) * mag(vel_m[1])
                                + mag(vel_m[2]) * mag(vel_m[2]));
                    ks = longint'(drag_m) * s;
                    f  = (((ks >> 24) * dt) << 4) + (((ks & 64'hFFFFFF) * dt) >> 20);
                    if (f > (64'd1 << 32)) f = 64'd1 << 32;  // drag at most stops
                    vel_m[0] = vel_next(vel_m[0], f, 0);
                    vel_m[1] = vel_next(vel_m[1], f, 0);
                    vel_m[2] = vel_next(vel_m[2], f, gdv);
                    for (int k = 0; k < 3; k++)
                        pos_m[k] = sat32(longint'(pos_m[k])
                                         + round_shift(longint'(vel_m[k]) * longint'(dt), 24));
                    r.ex = pos_m[0]; r.ey = pos_m[1]; r.ez = pos_m[2];
                    r.expired = 1'b0;
                    r.last    = (i == SUBSTEPS_DEF - 1);
                    seg_q.push_back(r);
                end
                return;
            end
        end
        // dead or out of life: one expiry result at the current position
        r = '{pos_m[0], pos_m[1], pos_m[2], pos_m[0], pos_m[1], pos_m[2], 1'b1, 1'b1};
        seg_q.push_back(r);
    endtask

    // ---------------- drivers ----------------
    task automatic send_req(logic op, logic signed [31:0] lx, ly, lz,
                            logic signed [15:0] ax, ay, az, logic [DT_W-1:0] dtv);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        repeat (gap) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.opcode     <= op;
        req_if.launch_x   <= lx;
        req_if.launch_y   <= ly;
        req_if.launch_z   <= lz;
        req_if.aim_x      <= ax;
        req_if.aim_y      <= ay;
        req_if.aim_z      <= az;
        req_if.delta_time <= dtv;
        do @(posedge i_clk); while (!req_if.ready);
        if (op == OP_LAUNCH) predict_launch(lx, ly, lz, ax, ay, az);
        else predict_tick(dtv);
    endtask

    task automatic launch(logic signed [31:0] lx, ly, lz, logic signed [15:0] ax, ay, az);
        send_req(OP_LAUNCH, lx, ly, lz, ax, ay, az, DT_W'($urandom));
    endtask

    task automatic tick(logic [DT_W-1:0] dtv);
        send_req(OP_TICK, $urandom, $urandom, $urandom,
                 16'($urandom), 16'($urandom), 16'($urandom), dtv);
    endtask

    // drain all results, then let a launch in flight finish
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (seg_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            CFG_MUZZLE_SPEED:   muz_m      = val[MUZ_W-1:0];
            CFG_DRAG_OVER_MASS: drag_m     = val[DRAG_W-1:0];
            CFG_MAX_LIFE:       max_life_m = val[LIFE_W-1:0];
            default:            grav_m     = val[GRAV_W-1:0];
        endcase
    endtask

    task automatic set_cfg(logic [MUZ_W-1:0] muz, logic [DRAG_W-1:0] drag,
                           logic [LIFE_W-1:0] life, logic [GRAV_W-1:0] grav);
        wait_idle();
        cfg_write(CFG_MUZZLE_SPEED, muz);
        cfg_write(CFG_DRAG_OVER_MASS, drag);
        cfg_write(CFG_MAX_LIFE, life);
        cfg_write(CFG_GRAVITY_Z, grav);
    endtask

    // ---------------- result checker ----------------
    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            n_err++;
        end
    endtask

    always @(posedge i_clk) begin
        t_seg e;
        if (rsp_if.valid && rsp_if.ready) begin
            if (seg_q.size() == 0) begin
                $error("result with no request pending");
                n_err++;
            end else begin
                e = seg_q.pop_front();
                check_field("seg_start_x", e.sx, rsp_if.seg_start_x);
                check_field("seg_start_y", e.sy, rsp_if.seg_start_y);
                check_field("seg_start_z", e.sz, rsp_if.seg_start_z);
                check_field("seg_end_x", e.ex, rsp_if.seg_end_x);
                check_field("seg_end_y", e.ey, rsp_if.seg_end_y);
                check_field("seg_end_z", e.ez, rsp_if.seg_end_z);
                check_field("expired", e.expired, rsp_if.expired);
                check_field("last", e.last, rsp_if.last);
            end
        end
    end

    // result backpressure: fresh stall length after each accepted result
    always @(posedge i_clk) begin
        int s;
        if (rsp_if.ready && rsp_if.valid) begin
            s = no_idle ? 0 : $urandom_range(0, 19);
            if (s != 0) begin
                rsp_if.ready <= 1'b0;
                rsp_stall <= s;
            end
        end else if (!rsp_if.ready) begin
            if (rsp_stall <= 1) rsp_if.ready <= 1'b1;
            rsp_stall <= rsp_stall - 1;
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_dead_tick();
        // fresh from reset the projectile is dead
        tick(18'h3FFFF);
        tick(0);
    endtask

    task automatic test_aim_special();
        launch(0, 0, 0, 0, 0, 0);     // zero aim
        tick(18'd4000);
        launch(100, -100, 7, 3, 1, 0);  // squared length exactly at the threshold
        tick(18'd4000);
        launch(-5, 5, 0, 3, 1, 1);      // just above the threshold
        tick(18'd4000);
        launch(0, 0, 0, -16'sd32768, -16'sd32768, -16'sd32768);
        tick(18'h3FFFF);
        launch(0, 0, 0, 16'sd32767, 16'sd32767, 16'sd32767);
        tick(0);                        // zero-length tick still makes four segments
    endtask

    task automatic test_position_saturation();
        set_cfg(18'h3FFFF, 16'd0, 26'h3FFFFFF, 13'h0FFF);
        launch(32'sh7FFFFF00, 32'sh80000100, 32'sh7FFFFFFF, 16'sd32767, -16'sd32768, 16'sd32767);
        tick(18'h3FFFF);
        tick(18'h3FFFF);
        launch(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, -16'sd32768, 16'sd32767, 0);
        tick(18'h3FFFF);
    endtask

    task automatic test_strong_drag();
        set_cfg(18'h3FFFF, 16'hFFFF, 26'h3FFFFFF, 13'h1000);  // minimum gravity
        launch(0, 0, 0, 16'sd20000, -16'sd9000, 16'sd1234);
        tick(18'h3FFFF);
        tick(18'h3FFFF);
    endtask

    task automatic test_life_expiry();
        set_cfg(18'd0, 16'd16, 26'd0, 13'h1C2C);  // zero speed, zero life
        launch(1000, 2000, 3000, 16'sd100, 16'sd100, 16'sd100);
        tick(0);        // life equal to limit still runs
        tick(1);        // passes the limit
        tick(18'd500);  // dead
        set_cfg(18'd80000, 16'd16, 26'd100000, 13'h1C2C);
        launch(0, 0, 0, 0, 16'sd32767, 0);
        repeat (3) tick(18'd40000);
    endtask

    task automatic test_random_flight(int n_items);
        int sent = 0;
        int n_ticks;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: lone tick or lone launch
                if ($urandom_range(0, 1) != 0) tick(DT_W'($urandom));
                else launch($urandom, $urandom, $urandom,
                            16'($urandom), 16'($urandom), 16'($urandom));
                sent++;
            end else begin
                launch($urandom, $urandom, $urandom,
                       16'($urandom), 16'($urandom), 16'($urandom));
                n_ticks = $urandom_range(1, 12);
                for (int i = 0; i < n_ticks; i++)
                    tick(($urandom_range(0, 3) == 0) ? DT_W'($urandom)
                                                     : DT_W'($urandom_range(0, 40000)));
                sent += n_ticks + 1;
            end
        end
    endtask

    initial begin
        muz_m = MUZZLE_RST; drag_m = DRAG_RST; max_life_m = MAX_LIFE_RST; grav_m = GRAV_RST;
        for (int k = 0; k < 3; k++) begin
            pos_m[k] = 0;
            vel_m[k] = 0;
        end
        life_m = 0;
        alive_m = 1'b0;
        req_if.valid = 1'b0; req_if.opcode = OP_LAUNCH;
        req_if.launch_x = 0; req_if.launch_y = 0; req_if.launch_z = 0;
        req_if.aim_x = 0; req_if.aim_y = 0; req_if.aim_z = 0; req_if.delta_time = 0;
        rsp_if.ready = 1'b1;
        cfg_if.valid = 1'b0; cfg_if.index = CFG_MUZZLE_SPEED; cfg_if.data = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_dead_tick();
        test_aim_special();
        test_position_saturation();
        test_strong_drag();
        test_life_expiry();

        // random phases, extremes first and next to last, one phase with no idling
        set_cfg(18'd0, 16'd0, 26'd0, 13'h1000);
        test_random_flight(40);
        set_cfg(MUZ_W'($urandom), DRAG_W'($urandom_range(0, 64)),
                LIFE_W'($urandom_range(1000000, 8000000)), GRAV_W'($urandom));
        test_random_flight(110);
        no_idle = 1'b1;
        set_cfg(MUZ_W'($urandom_range(1000, 200000)), DRAG_W'($urandom_range(0, 300)),
                LIFE_W'($urandom_range(2000000, 67108863)), GRAV_W'($urandom));
        test_random_flight(80);
        no_idle = 1'b0;
        set_cfg(18'h3FFFF, 16'hFFFF, 26'h3FFFFFF, 13'h0FFF);
        test_random_flight(60);
        set_cfg(MUZ_W'($urandom_range(10000, 200000)), DRAG_W'($urandom_range(1, 40)),
                26'd5242880, GRAV_W'($urandom));
        test_random_flight(100);

        wait_idle();
        if (n_err == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
